// File: sv/tcr_pkg.sv
// Shared constants, types and helpers of the touch calibration block.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

	localparam int unsigned RAW_W   = 10;
	localparam int unsigned COEF_W  = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [RAW_W-1:0]  MIN_PRESS          = 10'd10;
	localparam logic [RAW_W-1:0]  MAX_PRESS          = 10'd1000;
	localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_MS = 32'd10;
	localparam logic [TIME_W-1:0] RELEASE_DELAY_MS   = 32'd75;

	localparam logic [43:0] CAL_HALF    = 44'd5000;
	localparam logic [31:0] MIRROR_SPAN = 32'd10000;
	// 10000 = 16 * 625; ceil(2^40 / 625) is exact for quotients of 30-bit values
	localparam logic [9:0]  DIV_625     = 10'd625;
	localparam logic [30:0] RECIP_625   = 31'd1759218605;

	localparam logic KIND_MOVE    = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XOFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YOFF = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd7;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} tcr_stage_en_t;

	// signed quotient, optionally mirrored against the span
	function automatic logic [POS_W-1:0] place_coord(logic [30:0] mag, logic neg,
		logic mirror);
		logic [POS_W-1:0] m;
		logic [POS_W-1:0] base;
		logic [POS_W-1:0] term;
		m    = {1'b0, mag};
		base = mirror ? MIRROR_SPAN : '0;
		term = (neg ^ mirror) ? (~m + 32'd1) : m;
		return base + term;
	endfunction

endpackage

`default_nettype wire

// File: sv/touch_calibrate_and_report.sv
// Top level: sample gating, touch state, calibration pipeline and result register.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   raw_x, raw_y, pressure, now_ms
//  out       output     out_valid / out_ready kind, pos_x, pos_y
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// One request is taken every cycle unless a stalled output has filled the pipeline;
// its result passes through the input register, six stages per axis (products,
// rounded sum, magnitude, two reciprocal divides by 625) and the result register.
// Gating and touch state are decided in the cycle a request is taken, so
// requests without a result leave only a bubble. A stalled output holds its
// result; earlier stages keep filling until the pipeline is full.
// arst_n clears pipeline valids and touch state and sets config registers to reset values.
`timescale 1ns / 1ps
`default_nettype none

module touch_calibrate_and_report (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tcr_pkg::RAW_W-1:0]      raw_x,
	input  wire logic [tcr_pkg::RAW_W-1:0]      raw_y,
	input  wire logic [tcr_pkg::RAW_W-1:0]      pressure,
	input  wire logic [tcr_pkg::TIME_W-1:0]     now_ms,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                kind,
	output logic signed [tcr_pkg::POS_W-1:0]    pos_x,
	output logic signed [tcr_pkg::POS_W-1:0]    pos_y,
	input  wire logic                           cfg_we,
	input  wire logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcr_pkg::COEF_W-1:0]     cfg_data
);
	import tcr_pkg::*;

	logic [31:0] coef_xx_q, coef_xy_q, coef_xoff_q;
	logic [31:0] coef_yx_q, coef_yy_q, coef_yoff_q;
	logic [1:0]  rotation_q;
	logic        enable_q;

	logic [TIME_W-1:0] last_sample_q, last_touch_q;
	logic              touch_active_q;

	logic [8:1] vld_q;
	logic [8:1] adv;
	tcr_stage_en_t en;

	logic [9:0] x_s1, y_s1;
	logic kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6, kind_s7, kind_s8;
	logic [POS_W-1:0] pos_x_s8, pos_y_s8;

	logic [30:0] a_mag_s7, b_mag_s7;
	logic        a_neg_s7, b_neg_s7;

	logic [TIME_W-1:0] since_sample, since_touch;
	logic take, press_ok, rel, emit, in_fire;
	logic [POS_W-1:0] px, py;

	always_comb begin
		adv[8] = !vld_q[8] || out_ready;
		for (int k = 7; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign en.s2 = adv[2];
	assign en.s3 = adv[3];
	assign en.s4 = adv[4];
	assign en.s5 = adv[5];
	assign en.s6 = adv[6];
	assign en.s7 = adv[7];

	assign in_ready = adv[1];
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		since_sample = now_ms - last_sample_q;
		since_touch  = now_ms - last_touch_q;
		take     = enable_q && (since_sample >= SAMPLE_INTERVAL_MS);
		press_ok = (pressure > MIN_PRESS) && (pressure < MAX_PRESS);
		rel      = touch_active_q && (since_touch >= RELEASE_DELAY_MS);
		emit     = take && (press_ok || rel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q   <= 32'd10000;
			coef_xy_q   <= '0;
			coef_xoff_q <= '0;
			coef_yx_q   <= '0;
			coef_yy_q   <= 32'd10000;
			coef_yoff_q <= '0;
			rotation_q  <= ROT_0;
			enable_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_XX:   coef_xx_q   <= cfg_data;
				REG_COEF_XY:   coef_xy_q   <= cfg_data;
				REG_COEF_XOFF: coef_xoff_q <= cfg_data;
				REG_COEF_YX:   coef_yx_q   <= cfg_data;
				REG_COEF_YY:   coef_yy_q   <= cfg_data;
				REG_COEF_YOFF: coef_yoff_q <= cfg_data;
				REG_ROTATION:  rotation_q  <= cfg_data[1:0];
				REG_ENABLE:    enable_q    <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= '0;
			last_touch_q   <= '0;
			touch_active_q <= 1'b0;
		end else if (in_fire && take) begin
			last_sample_q <= now_ms;
			if (press_ok) begin
				touch_active_q <= 1'b1;
				last_touch_q   <= now_ms;
			end else if (rel) begin
				touch_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid && emit;
			for (int k = 2; k <= 8; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1    <= raw_x;
			y_s1    <= raw_y;
			kind_s1 <= press_ok ? KIND_MOVE : KIND_RELEASE;
		end
		if (adv[2]) kind_s2 <= kind_s1;
		if (adv[3]) kind_s3 <= kind_s2;
		if (adv[4]) kind_s4 <= kind_s3;
		if (adv[5]) kind_s5 <= kind_s4;
		if (adv[6]) kind_s6 <= kind_s5;
		if (adv[7]) kind_s7 <= kind_s6;
		if (adv[8]) begin
			kind_s8 <= kind_s7;
			if (kind_s7 == KIND_RELEASE) begin
				pos_x_s8 <= '0;
				pos_y_s8 <= '0;
			end else begin
				pos_x_s8 <= px;
				pos_y_s8 <= py;
			end
		end
	end

	tcr_axis u_axis_a (
		.clk      (clk),
		.en       (en),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.coef_x   (coef_xx_q),
		.coef_y   (coef_xy_q),
		.coef_off (coef_xoff_q),
		.mag_s7   (a_mag_s7),
		.neg_s7   (a_neg_s7)
	);

	tcr_axis u_axis_b (
		.clk      (clk),
		.en       (en),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.coef_x   (coef_yx_q),
		.coef_y   (coef_yy_q),
		.coef_off (coef_yoff_q),
		.mag_s7   (b_mag_s7),
		.neg_s7   (b_neg_s7)
	);

	always_comb begin
		unique case (rotation_q)
			ROT_0: begin
				px = place_coord(a_mag_s7, a_neg_s7, 1'b0);
				py = place_coord(b_mag_s7, b_neg_s7, 1'b0);
			end
			ROT_90: begin
				px = place_coord(b_mag_s7, b_neg_s7, 1'b1);
				py = place_coord(a_mag_s7, a_neg_s7, 1'b0);
			end
			ROT_180: begin
				px = place_coord(a_mag_s7, a_neg_s7, 1'b1);
				py = place_coord(b_mag_s7, b_neg_s7, 1'b1);
			end
			ROT_270: begin
				px = place_coord(b_mag_s7, b_neg_s7, 1'b0);
				py = place_coord(a_mag_s7, a_neg_s7, 1'b1);
			end
		endcase
	end

	assign out_valid = vld_q[8];
	assign kind      = kind_s8;
	assign pos_x     = $signed(pos_x_s8);
	assign pos_y     = $signed(pos_y_s8);

endmodule

`default_nettype wire

// File: sv/tcr_axis.sv
// One calibrated axis: products, rounded sum and truncating divide by 10000.
`timescale 1ns / 1ps
`default_nettype none

module tcr_axis (
	input  wire logic                   clk,
	input  wire tcr_pkg::tcr_stage_en_t en,
	input  wire logic [9:0]             x_s1,
	input  wire logic [9:0]             y_s1,
	input  wire logic [31:0]            coef_x,
	input  wire logic [31:0]            coef_y,
	input  wire logic [31:0]            coef_off,
	output logic [30:0]                 mag_s7,
	output logic                        neg_s7
);
	import tcr_pkg::*;

	logic [42:0] pa_s2, pb_s2;
	logic [43:0] sum_s3;
	logic [39:0] n_s4;
	logic        neg_s4, neg_s5, neg_s6;
	logic [10:0] qhi_s5, qhi_s6;
	logic [19:0] hi_s5, lo_s5;
	logic [29:0] v_s6;

	logic [43:0] mag;
	logic [50:0] prod_hi;
	logic [20:0] back;
	logic [19:0] rem;
	logic [60:0] prod_lo;

	always_comb begin
		mag     = sum_s3[43] ? (~sum_s3 + 44'd1) : sum_s3;
		prod_hi = 51'(n_s4[39:20]) * 51'(RECIP_625);
		back    = 21'(qhi_s5) * 21'(DIV_625);
		rem     = hi_s5 - back[19:0];
		prod_lo = 61'(v_s6) * 61'(RECIP_625);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pa_s2 <= 43'($signed(coef_x) * $signed({1'b0, x_s1}));
			pb_s2 <= 43'($signed(coef_y) * $signed({1'b0, y_s1}));
		end
		if (en.s3) begin
			sum_s3 <= {pa_s2[42], pa_s2} + {pb_s2[42], pb_s2}
				+ {{12{coef_off[31]}}, coef_off} + CAL_HALF;
		end
		if (en.s4) begin
			n_s4   <= mag[43:4];
			neg_s4 <= sum_s3[43];
		end
		if (en.s5) begin
			qhi_s5 <= prod_hi[50:40];
			hi_s5  <= n_s4[39:20];
			lo_s5  <= n_s4[19:0];
			neg_s5 <= neg_s4;
		end
		if (en.s6) begin
			v_s6   <= {rem[9:0], lo_s5};
			qhi_s6 <= qhi_s5;
			neg_s6 <= neg_s5;
		end
		if (en.s7) begin
			mag_s7 <= {qhi_s6, prod_lo[59:40]};
			neg_s7 <= neg_s6;
		end
	end

endmodule

`default_nettype wire

// File: sv/tcr_checker.sv
// Port-level checks of the touch calibration block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module tcr_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic                           kind,
	input wire logic signed [tcr_pkg::POS_W-1:0] pos_x,
	input wire logic signed [tcr_pkg::POS_W-1:0] pos_y
);
	import tcr_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind)
			&& $stable(pos_x) && $stable(pos_y))
		else $error("stalled result changed");

	// release carries no coordinates
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_RELEASE) |-> (pos_x == 0) && (pos_y == 0))
		else $error("release with nonzero coordinates");

	// free output slot lets the pipeline advance
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while output can drain");

	// no result right after reset release
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result present after reset");

endmodule

bind touch_calibrate_and_report tcr_checker u_tcr_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for touch_calibrate_and_report: directed and random touch traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

	import tcr_pkg::*;

	localparam longint CAL_ROUND     = 5000;
	localparam longint CAL_DIVISOR   = 10000;
	localparam longint FLIP_SPAN     = 10000;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     CYCLE_LIMIT   = 500000;
	localparam int     PHASE_ITEMS   = 220;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} touch_report_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [RAW_W-1:0]         raw_x     = '0;
	logic [RAW_W-1:0]         raw_y     = '0;
	logic [RAW_W-1:0]         pressure  = '0;
	logic [TIME_W-1:0]        now_ms    = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     kind;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_COEF_XX;
	logic [COEF_W-1:0]        cfg_data  = '0;

	logic [COEF_W-1:0] cfg_shadow [0:7];
	logic [TIME_W-1:0] last_sample_ms = '0;
	logic              touch_down     = 1'b0;
	logic [TIME_W-1:0] last_touch_ms  = '0;
	logic [TIME_W-1:0] stamp_ms       = '0;

	touch_report_t expected_reports [$];
	int            error_count = 0;
	int            gated_count = 0;
	int            burst_left  = 0;
	int unsigned   cycle_count = 0;

	touch_calibrate_and_report i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.pressure  (pressure),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic longint calibrated_axis(logic [COEF_W-1:0] wx, logic [COEF_W-1:0] wy,
		logic [COEF_W-1:0] bias, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
		longint acc;
		acc = longint'($signed(wx)) * longint'(x) + longint'($signed(wy)) * longint'(y)
			+ longint'($signed(bias)) + CAL_ROUND;
		return acc / CAL_DIVISOR;
	endfunction

	task automatic predict_report(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
		input logic [RAW_W-1:0] p, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] since;
		longint a, b, px, py;
		touch_report_t rep;
		if (!cfg_shadow[REG_ENABLE][0])
			return;
		since = t - last_sample_ms;
		if (since < SAMPLE_INTERVAL_MS)
			return;
		last_sample_ms = t;
		gated_count++;
		if (p > MIN_PRESS && p < MAX_PRESS) begin
			a = calibrated_axis(cfg_shadow[REG_COEF_XX], cfg_shadow[REG_COEF_XY],
				cfg_shadow[REG_COEF_XOFF], x, y);
			b = calibrated_axis(cfg_shadow[REG_COEF_YX], cfg_shadow[REG_COEF_YY],
				cfg_shadow[REG_COEF_YOFF], x, y);
			case (cfg_shadow[REG_ROTATION][1:0])
				ROT_90: begin
					px = FLIP_SPAN - b;
					py = a;
				end
				ROT_180: begin
					px = FLIP_SPAN - a;
					py = FLIP_SPAN - b;
				end
				ROT_270: begin
					px = b;
					py = FLIP_SPAN - a;
				end
				default: begin
					px = a;
					py = b;
				end
			endcase
			touch_down = 1'b1;
			last_touch_ms = t;
			rep.kind = KIND_MOVE;
			rep.pos_x = px[POS_W-1:0];
			rep.pos_y = py[POS_W-1:0];
			expected_reports.push_back(rep);
		end else begin
			since = t - last_touch_ms;
			if (touch_down && since >= RELEASE_DELAY_MS) begin
				touch_down = 1'b0;
				rep.kind = KIND_RELEASE;
				rep.pos_x = '0;
				rep.pos_y = '0;
				expected_reports.push_back(rep);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [POS_W-1:0] want,
		input logic [POS_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : report_check
		touch_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t unexpected report: expected none actual kind %0d pos %h %h",
					$time, kind, pos_x, pos_y);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				compare_field("kind", POS_W'(want.kind), POS_W'(kind));
				compare_field("pos_x", want.pos_x, pos_x);
				compare_field("pos_y", want.pos_y, pos_y);
			end
		end
	end

	always @(posedge clk) begin : sink_pattern
		int sink_mode;
		int sink_left;
		int sink_tick;
		if (sink_left == 0) begin
			sink_mode = $urandom_range(0, 2);
			sink_left = $urandom_range(40, 300);
		end else begin
			sink_left--;
		end
		sink_tick++;
		case (sink_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ((sink_tick % 5) < 2);
		endcase
	end

	task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
		input logic [RAW_W-1:0] p, input logic [TIME_W-1:0] t);
		in_valid <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		pressure <= p;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
		predict_report(x, y, p, t);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic settle_block;
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config;
		settle_block();
		for (int r = REG_COEF_XX; r <= REG_ENABLE; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			cfg_data <= cfg_shadow[CFG_IDX_W'(r)];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [RAW_W-1:0] press_in();
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 1) != 0) ? MIN_PRESS + 10'd1 : MAX_PRESS - 10'd1;
		return RAW_W'($urandom_range(MIN_PRESS + 1, MAX_PRESS - 1));
	endfunction

	function automatic logic [RAW_W-1:0] press_out();
		if ($urandom_range(0, 1) != 0)
			return RAW_W'($urandom_range(0, MIN_PRESS));
		return RAW_W'($urandom_range(MAX_PRESS, 1023));
	endfunction

	function automatic logic [RAW_W-1:0] raw_pick();
		return RAW_W'($urandom_range(0, 1023));
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 40000) - 20000;
			3: return $urandom();
			4: return '0;
			default: return ($urandom_range(0, 1) != 0) ? 32'd10000 : -32'sd10000;
		endcase
	endfunction

	task automatic test_disabled;
		cfg_shadow[REG_COEF_XX] = 32'd10000;
		cfg_shadow[REG_COEF_XY] = '0;
		cfg_shadow[REG_COEF_XOFF] = '0;
		cfg_shadow[REG_COEF_YX] = '0;
		cfg_shadow[REG_COEF_YY] = 32'd10000;
		cfg_shadow[REG_COEF_YOFF] = '0;
		cfg_shadow[REG_ROTATION] = COEF_W'(ROT_0);
		cfg_shadow[REG_ENABLE] = '0;
		apply_config();
		send_sample(10'd512, 10'd512, 10'd500, 32'd100);
		send_sample(10'd3, 10'd900, 10'd500, 32'd200);
	endtask

	task automatic test_pressure_window;
		cfg_shadow[REG_ENABLE] = 32'd1;
		apply_config();
		send_sample(10'd0, 10'd0, MIN_PRESS + 10'd1, 32'd1000);
		send_sample(10'd1023, 10'd1023, MAX_PRESS - 10'd1, 32'd1010);
		send_sample(10'd77, 10'd88, MIN_PRESS, 32'd1020);
		send_sample(10'd77, 10'd88, MAX_PRESS, 32'd1084);
		send_sample(10'd77, 10'd88, MAX_PRESS, 32'd1085);
	endtask

	task automatic test_sample_interval;
		send_sample(10'd500, 10'd500, 10'd0, 32'd1090);
		send_sample(10'd500, 10'd500, 10'd1023, 32'd1094);
		send_sample(10'd1, 10'd2, 10'd500, 32'd1095);
		send_sample(10'd600, 10'd400, 10'd500, 32'd1105);
	endtask

	task automatic test_time_wrap;
		send_sample(10'd300, 10'd700, 10'd500, 32'hFFFF_FFF8);
		send_sample(10'd300, 10'd700, 10'd1023, 32'h0000_0002);
		send_sample(10'd300, 10'd700, 10'd5, 32'h0000_0042);
		send_sample(10'd300, 10'd700, 10'd5, 32'h0000_0043);
		stamp_ms = 32'h0000_0043;
	endtask

	task automatic test_rotation;
		cfg_shadow[REG_COEF_XX] = 32'd20000;
		cfg_shadow[REG_COEF_XY] = -32'sd3000;
		cfg_shadow[REG_COEF_XOFF] = -32'sd7000;
		cfg_shadow[REG_COEF_YX] = 32'd1500;
		cfg_shadow[REG_COEF_YY] = -32'sd10000;
		cfg_shadow[REG_COEF_YOFF] = 32'd12345678;
		for (int r = ROT_0; r <= ROT_270; r++) begin
			cfg_shadow[REG_ROTATION] = COEF_W'(r);
			apply_config();
			stamp_ms += 50;
			send_sample(10'd700, 10'd300, 10'd400, stamp_ms);
		end
	endtask

	task automatic test_coef_extremes;
		for (int r = REG_COEF_XX; r <= REG_COEF_YOFF; r++)
			cfg_shadow[CFG_IDX_W'(r)] = 32'h7FFF_FFFF;
		cfg_shadow[REG_ROTATION] = COEF_W'(ROT_180);
		apply_config();
		stamp_ms += 50;
		send_sample(10'd1023, 10'd1023, 10'd400, stamp_ms);
		stamp_ms += 50;
		send_sample(10'd0, 10'd1023, 10'd400, stamp_ms);
		for (int r = REG_COEF_XX; r <= REG_COEF_YOFF; r++)
			cfg_shadow[CFG_IDX_W'(r)] = 32'h8000_0000;
		cfg_shadow[REG_ROTATION] = COEF_W'(ROT_270);
		apply_config();
		stamp_ms += 50;
		send_sample(10'd1023, 10'd1023, 10'd400, stamp_ms);
		stamp_ms += 50;
		send_sample(10'd1023, 10'd0, 10'd400, stamp_ms);
	endtask

	task automatic run_touch_traffic(input int target);
		int stop_at;
		int pick;
		stop_at = gated_count + target;
		while (gated_count < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				repeat ($urandom_range(1, 12)) begin
					stamp_ms += ($urandom_range(0, 7) == 0) ? SAMPLE_INTERVAL_MS
						: $urandom_range(10, 40);
					send_sample(raw_pick(), raw_pick(), press_in(), stamp_ms);
				end
				repeat ($urandom_range(1, 4)) begin
					stamp_ms += $urandom_range(10, 60);
					send_sample(raw_pick(), raw_pick(), press_out(), stamp_ms);
				end
			end else if (pick < 85) begin
				stamp_ms += $urandom_range(0, 15);
				send_sample(raw_pick(), raw_pick(), raw_pick(), stamp_ms);
			end else if (pick < 93) begin
				stamp_ms = ($urandom_range(0, 1) != 0) ? $urandom()
					: 32'hFFFF_FFFF - $urandom_range(0, 40);
				send_sample(raw_pick(), raw_pick(), press_in(), stamp_ms);
			end else begin
				stamp_ms += $urandom_range(10, 30);
				send_sample(raw_pick(), raw_pick(), press_in(), stamp_ms);
				stamp_ms += $urandom_range(60, 90);
				send_sample(raw_pick(), raw_pick(), press_out(), stamp_ms);
			end
		end
	endtask

	task automatic test_random_touch;
		logic [1:0] rot;
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = REG_COEF_XX; r <= REG_COEF_YOFF; r++) begin
				case (ph)
					0: cfg_shadow[CFG_IDX_W'(r)] =
						(r == REG_COEF_XX || r == REG_COEF_YY) ? 32'd10000 : '0;
					1: cfg_shadow[CFG_IDX_W'(r)] = 32'h7FFF_FFFF;
					2: cfg_shadow[CFG_IDX_W'(r)] = 32'h8000_0000;
					default: cfg_shadow[CFG_IDX_W'(r)] = pick_coef();
				endcase
			end
			rot = 2'(ph);
			cfg_shadow[REG_ROTATION] = ($urandom() & ~32'd3) | COEF_W'(rot);
			cfg_shadow[REG_ENABLE] = ($urandom() & ~32'd1) | 32'd1;
			apply_config();
			run_touch_traffic(PHASE_ITEMS);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_pressure_window();
		test_sample_interval();
		test_time_wrap();
		test_rotation();
		test_coef_extremes();
		test_random_touch();
		settle_block();
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
sv/tcr_pkg.sv
sv/tcr_axis.sv
sv/touch_calibrate_and_report.sv
sv/tcr_checker.sv
sim/tb_top.sv
